>>> rtl/ncl_pkg.sv
// ----------------------------------------------------------------------------
// ncl_pkg
// Shared types and constants for the node cache LRU policy block.
// ----------------------------------------------------------------------------
`default_nettype none

package ncl_pkg;

  localparam int SLOTS_DEF  = 32;
  localparam int BLOCK_BITS = 32;
  localparam int SLOT_BITS  = 5;
  localparam int STAMP_BITS = 64;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_FLUSH = 2'd3
  } ncl_op_t;

  typedef struct packed {
    ncl_op_t               opcode;
    logic [BLOCK_BITS-1:0] block_number;
    logic [SLOT_BITS-1:0]  slot_index;
  } ncl_in_t;

  typedef struct packed {
    logic [SLOT_BITS-1:0]  slot;
    logic                  hit;
    logic                  fill_needed;
    logic                  writeback;
    logic [BLOCK_BITS-1:0] writeback_block;
  } ncl_out_t;

  // One slot of the tag store.
  typedef struct packed {
    logic [BLOCK_BITS-1:0] tag;
    logic [STAMP_BITS-1:0] stamp;
    logic                  dirty;
  } ncl_entry_t;

endpackage

`default_nettype wire

>>> rtl/ncl_stream_if.sv
// ----------------------------------------------------------------------------
// ncl_stream_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface ncl_stream_if #(
  parameter type T = logic
) ();

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

>>> rtl/ncl_ram.sv
// ----------------------------------------------------------------------------
// ncl_ram
// Slot entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ncl_ram import ncl_pkg::*; #(
  parameter int DEPTH = SLOTS_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  ncl_entry_t               wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output ncl_entry_t               rd_data
);

  ncl_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/node_cache_lru_policy.sv
// ----------------------------------------------------------------------------
// node_cache_lru_policy
// Tag and replacement controller for a fully associative block cache.
// ----------------------------------------------------------------------------
// Usage:
//   in_if  carries one request per transfer: opcode (load, alloc, free,
//          flush), block number and, for flush, a slot index.
//   out_if returns exactly one result per request: slot, hit, fill_needed,
//          writeback and writeback_block, in request order.
//   Load/alloc/free walk every slot of the entry RAM, one read per cycle,
//   tracking the first tag match, the first empty slot and the slot with the
//   oldest stamp. A flush reads just its own slot's entry; an out-of-range
//   flush reads none. The walk passes through the scan and drain states to
//   the update state, which registers the result; only then does the block
//   take its next request. The single RAM read port paces the walk.
//   The result sits in an output register, so the next request is taken
//   while it waits; a stalled receiver holds the block only once the next
//   result is ready to be written.
//   Reset clears the valid bits and the use clock at once; the RAM itself
//   is not cleared, since an entry is read only behind its valid bit.
// ----------------------------------------------------------------------------
`default_nettype none

module node_cache_lru_policy import ncl_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  ncl_stream_if.sink   in_if,
  ncl_stream_if.source out_if
);

  localparam int IW = $clog2(SLOTS);
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_UPDATE = 4'b1000
  } state_t;

  state_t                state_r;
  logic                  rsp_vld_r;
  logic [IW-1:0]         rsp_idx_r;
  logic [IW-1:0]         cnt_r;
  logic [IW-1:0]         last_r;
  logic [SLOTS-1:0]      valid_r;
  logic [STAMP_BITS-1:0] use_clock_r;
  logic                  out_valid_r;
  ncl_out_t              out_data_r;

  // Request held for the whole walk.
  ncl_op_t               op_r;
  logic [BLOCK_BITS-1:0] blk_r;
  logic [SLOT_BITS-1:0]  idx_r;
  logic                  idx_ok_r;

  // Scan results.
  logic                  found_r;
  logic [IW-1:0]         match_idx_r;
  logic                  match_dirty_r;
  logic                  free_found_r;
  logic [IW-1:0]         free_idx_r;
  logic                  min_any_r;
  logic [IW-1:0]         min_idx_r;
  logic [STAMP_BITS-1:0] min_stamp_r;
  logic [BLOCK_BITS-1:0] min_tag_r;
  logic                  min_dirty_r;

  ncl_entry_t            rd_data;
  logic                  rd_en;
  logic                  in_xfer;
  logic                  in_idx_ok;
  logic                  go;
  logic                  rsp_live;

  // Update-stage decisions.
  logic [STAMP_BITS-1:0] clk_nxt;
  logic [IW-1:0]         victim_idx;
  logic                  victim_wb;
  logic [IW-1:0]         tgt;
  logic                  wr_want;
  ncl_entry_t            wr_data;
  logic                  stamp_upd;
  logic                  clr_valid;
  ncl_out_t              res;

  assign in_if.ready  = (state_r == S_IDLE);
  assign in_xfer      = in_if.valid && in_if.ready;
  assign in_idx_ok    = 32'(in_if.data.slot_index) < 32'(SLOTS);
  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_data_r;
  assign rd_en        = (state_r == S_SCAN);
  assign go           = (state_r == S_UPDATE) && (!out_valid_r || out_if.ready);
  assign rsp_live     = rsp_vld_r && valid_r[rsp_idx_r];

  ncl_ram #(.DEPTH(SLOTS)) u_ram (
    .clk     (clk),
    .wr_en   (go && wr_want),
    .wr_addr (tgt),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (cnt_r),
    .rd_data (rd_data)
  );

  // Work out the result and the write-back entry from the scan registers.
  always_comb begin
    clk_nxt    = use_clock_r + STAMP_BITS'(1);
    victim_idx = free_found_r ? free_idx_r : min_idx_r;
    victim_wb  = !free_found_r && min_dirty_r && (min_tag_r != '0);
    tgt        = victim_idx;
    wr_want    = 1'b0;
    wr_data    = '{tag: blk_r, stamp: clk_nxt, dirty: 1'b0};
    stamp_upd  = 1'b0;
    clr_valid  = 1'b0;
    res        = '0;
    case (op_r)
      OP_LOAD: begin
        stamp_upd = 1'b1;
        wr_want   = 1'b1;
        if (found_r) begin
          tgt           = match_idx_r;
          res.hit       = 1'b1;
          wr_data.dirty = match_dirty_r;
        end else begin
          res.fill_needed     = 1'b1;
          res.writeback       = victim_wb;
          res.writeback_block = victim_wb ? min_tag_r : '0;
        end
        res.slot = SLOT_BITS'(tgt);
      end
      OP_ALLOC: begin
        stamp_upd           = 1'b1;
        wr_want             = 1'b1;
        wr_data.dirty       = 1'b1;
        res.writeback       = victim_wb;
        res.writeback_block = victim_wb ? min_tag_r : '0;
        res.slot            = SLOT_BITS'(tgt);
      end
      OP_FREE: begin
        tgt = match_idx_r;
        if (found_r) begin
          clr_valid = 1'b1;
          res.hit   = 1'b1;
          res.slot  = SLOT_BITS'(match_idx_r);
        end
      end
      OP_FLUSH: begin
        tgt      = min_idx_r;
        res.slot = idx_r;
        // Only a resident slot is written back; keep its stamp, drop dirty.
        if (idx_ok_r && min_any_r) begin
          wr_want             = 1'b1;
          wr_data             = '{tag: min_tag_r, stamp: min_stamp_r, dirty: 1'b0};
          res.writeback       = 1'b1;
          res.writeback_block = min_tag_r;
        end
      end
      default: ;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      rsp_vld_r    <= 1'b0;
      valid_r      <= '0;
      use_clock_r  <= '0;
      out_valid_r  <= 1'b0;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
      min_any_r    <= 1'b0;
    end else begin
      rsp_vld_r <= (state_r == S_SCAN);
      if (out_valid_r && out_if.ready && !go) begin
        out_valid_r <= 1'b0;
      end
      // Fold in the entry read last cycle.
      if (rsp_live && !found_r && (rd_data.tag == blk_r)) begin
        found_r <= 1'b1;
      end
      if (rsp_vld_r && !valid_r[rsp_idx_r]) begin
        free_found_r <= 1'b1;
      end
      if (rsp_live) begin
        min_any_r <= 1'b1;
      end
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            found_r      <= 1'b0;
            free_found_r <= 1'b0;
            min_any_r    <= 1'b0;
            if (in_if.data.opcode == OP_FLUSH && !in_idx_ok) begin
              state_r <= S_UPDATE;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (cnt_r == last_r) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state_r <= S_UPDATE;
        end
        S_UPDATE: begin
          if (go) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
            if (stamp_upd) begin
              use_clock_r  <= clk_nxt;
              // A stamp that wrapped to zero leaves the slot empty.
              valid_r[tgt] <= (clk_nxt != '0);
            end
            if (clr_valid) begin
              valid_r[tgt] <= 1'b0;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    rsp_idx_r <= cnt_r;
    if (in_xfer) begin
      op_r     <= in_if.data.opcode;
      blk_r    <= in_if.data.block_number;
      idx_r    <= in_if.data.slot_index;
      idx_ok_r <= in_idx_ok;
      if (in_if.data.opcode == OP_FLUSH) begin
        cnt_r  <= IW'(in_if.data.slot_index);
        last_r <= IW'(in_if.data.slot_index);
      end else begin
        cnt_r  <= '0;
        last_r <= LAST_IDX;
      end
    end else if (state_r == S_SCAN && cnt_r != last_r) begin
      cnt_r <= cnt_r + IW'(1);
    end
    if (rsp_live && !found_r && (rd_data.tag == blk_r)) begin
      match_idx_r   <= rsp_idx_r;
      match_dirty_r <= rd_data.dirty;
    end
    if (rsp_vld_r && !valid_r[rsp_idx_r] && !free_found_r) begin
      free_idx_r <= rsp_idx_r;
    end
    // Strict compare keeps the lowest slot on equal stamps.
    if (rsp_live && (!min_any_r || rd_data.stamp < min_stamp_r)) begin
      min_idx_r   <= rsp_idx_r;
      min_stamp_r <= rd_data.stamp;
      min_tag_r   <= rd_data.tag;
      min_dirty_r <= rd_data.dirty;
    end
    if (go) begin
      out_data_r <= res;
    end
  end

`ifndef SYNTHESIS
  a_rsp_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    rsp_vld_r |-> (state_r == S_SCAN || state_r == S_DRAIN))
    else $error("read response outside of a slot walk");

  a_update_emits: assert property (@(posedge clk) disable iff (!rst_n)
    go |=> out_valid_r)
    else $error("update step did not present a result");

  a_victim_known: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPDATE && !free_found_r &&
     ((op_r == OP_LOAD && !found_r) || op_r == OP_ALLOC)) |-> min_any_r)
    else $error("full cache without an oldest slot");

  a_match_resident: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPDATE && found_r) |-> valid_r[match_idx_r])
    else $error("matched slot is not resident");
`endif

endmodule

`default_nettype wire

>>> tb/tb_node_cache_lru_policy.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_node_cache_lru_policy
// Self-checking bench for the fully associative LRU tag controller.
// ----------------------------------------------------------------------------
// Requests go in through a valid/ready channel. Each accepted transfer runs
// through a behavioral copy of the tag store (tags, age stamps, dirty bits
// and the use clock). The reply that copy computes is queued, and each reply
// transfer from the block is compared field by field with the oldest queued
// one. The tests run in turn:
//   - directed: empty-cache miss, hit, block zero and all-ones, duplicate
//     alloc, free hit and miss, flush of valid, clean and invalid slots
//   - fill and evict: fill every slot with dirty blocks, then force misses
//     so that oldest-stamp victims and writebacks show up
//   - random mix drawn mostly from a small block pool, so hits, evictions
//     and frees keep happening
//   - backpressure: the receiver holds off for a long stretch while the
//     sender keeps offering requests, so the block fills up and stalls
//   - streaming: random requests with no idling on either side
// A watchdog ends the run if no transfer happens for too long.
// ----------------------------------------------------------------------------

module tb_node_cache_lru_policy;
  import ncl_pkg::*;

  localparam int CLK_HALF    = 6;
  localparam int RESET_CYC   = 9;
  localparam int POOL_SIZE   = 40;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYC   = 48;
  localparam int HOLD_CYC    = 160;
  localparam int REPORT_MAX  = 10;

  logic clk;
  logic rst_n;

  ncl_stream_if #(.T(ncl_in_t))  in_ch ();
  ncl_stream_if #(.T(ncl_out_t)) out_ch ();

  node_cache_lru_policy dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  // Shadow copy of the tag store; a stamp of zero marks an empty slot.
  logic [BLOCK_BITS-1:0] tag_q   [SLOTS_DEF];
  logic [STAMP_BITS-1:0] stamp_q [SLOTS_DEF];
  bit                    dirty_q [SLOTS_DEF];
  logic [STAMP_BITS-1:0] use_clk;

  ncl_out_t              reply_q [$];
  logic [BLOCK_BITS-1:0] block_pool [POOL_SIZE];

  bit idle_enable;
  int hold_request;
  int mismatch_cnt;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Shadow tag store
  // --------------------------------------------------------------------------

  // Lowest-numbered valid slot holding blk, or -1.
  function automatic int find_resident(logic [BLOCK_BITS-1:0] blk);
    int found;
    found = -1;
    for (int i = SLOTS_DEF - 1; i >= 0; i--)
      if (stamp_q[i] != '0 && tag_q[i] == blk) found = i;
    return found;
  endfunction

  // Apply one request to the shadow store and return the reply it causes.
  function automatic ncl_out_t predict_cache_reply(ncl_in_t req);
    ncl_out_t              res;
    int                    s;
    bit                    have_free;
    logic [STAMP_BITS-1:0] oldest;
    res = '0;
    case (req.opcode)
      OP_LOAD, OP_ALLOC: begin
        // alloc never looks for an existing copy of the block
        s = (req.opcode == OP_LOAD) ? find_resident(req.block_number) : -1;
        if (s >= 0) begin
          res.hit = 1'b1;
        end else begin
          // take the first empty slot; with none, the oldest stamp,
          // lowest index on ties
          have_free = 1'b0;
          oldest    = '1;
          s         = 0;
          for (int i = 0; i < SLOTS_DEF; i++) begin
            if (!have_free) begin
              if (stamp_q[i] == '0) begin
                have_free = 1'b1;
                s         = i;
              end else if (stamp_q[i] < oldest) begin
                oldest = stamp_q[i];
                s      = i;
              end
            end
          end
          // a dirty victim goes back to storage unless it holds block zero
          if (!have_free && dirty_q[s] && tag_q[s] != '0) begin
            res.writeback       = 1'b1;
            res.writeback_block = tag_q[s];
          end
          tag_q[s]        = req.block_number;
          dirty_q[s]      = (req.opcode == OP_ALLOC);
          res.fill_needed = (req.opcode == OP_LOAD);
        end
        use_clk    = use_clk + 1'b1;
        stamp_q[s] = use_clk;
        res.slot   = 5'(s);
      end
      OP_FREE: begin
        s = find_resident(req.block_number);
        if (s >= 0) begin
          res.hit    = 1'b1;
          res.slot   = 5'(s);
          stamp_q[s] = '0;
          dirty_q[s] = 1'b0;
        end
      end
      OP_FLUSH: begin
        res.slot = req.slot_index;
        if (int'(req.slot_index) < SLOTS_DEF) begin
          // a valid slot is always written back, clean or not
          if (stamp_q[req.slot_index] != '0) begin
            res.writeback       = 1'b1;
            res.writeback_block = tag_q[req.slot_index];
          end
          dirty_q[req.slot_index] = 1'b0;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------

  // Offer one request from a falling edge, wait for the transfer, queue the
  // predicted reply and return on the next falling edge. Valid stays high
  // between back-to-back requests.
  task automatic send_req(input ncl_op_t op, input logic [BLOCK_BITS-1:0] blk,
                          input logic [SLOT_BITS-1:0] idx);
    ncl_in_t req;
    req.opcode       = op;
    req.block_number = blk;
    req.slot_index   = idx;
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= req;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    reply_q.push_back(predict_cache_reply(req));
    @(negedge clk);
  endtask

  // Mostly pool blocks so that hits and evictions recur; now and then a
  // fully random block to toggle every address bit.
  function automatic logic [BLOCK_BITS-1:0] pick_block();
    if ($urandom_range(0, 19) == 0) return $urandom();
    return block_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  task automatic send_random_req();
    int      roll;
    ncl_op_t op;
    roll = $urandom_range(0, 99);
    if (roll < 45)      op = OP_LOAD;
    else if (roll < 70) op = OP_ALLOC;
    else if (roll < 85) op = OP_FREE;
    else                op = OP_FLUSH;
    send_req(op, pick_block(), 5'($urandom_range(0, 31)));
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  task automatic test_directed();
    // miss into an empty cache, then hit; block zero is a legal block
    send_req(OP_LOAD,  32'h0000_0000, 5'h1f);
    send_req(OP_LOAD,  32'h0000_0000, 5'h00);
    // duplicate alloc: two copies, lookups find the lower slot
    send_req(OP_ALLOC, 32'hffff_ffff, 5'h15);
    send_req(OP_ALLOC, 32'hffff_ffff, 5'h0a);
    send_req(OP_LOAD,  32'hffff_ffff, 5'h1f);
    send_req(OP_FREE,  32'hffff_ffff, 5'h00);
    send_req(OP_LOAD,  32'hffff_ffff, 5'h1f);
    // free miss leaves everything alone
    send_req(OP_FREE,  32'h1234_5678, 5'h1f);
    // flush a dirty slot, then the same slot once clean
    send_req(OP_FLUSH, 32'hffff_ffff, 5'd2);
    send_req(OP_FLUSH, 32'h0000_0000, 5'd2);
    // flush of empty slots: no writeback
    send_req(OP_FLUSH, 32'hffff_ffff, 5'd1);
    send_req(OP_FLUSH, 32'h0000_0000, 5'd31);
    // alloc refills the first hole; flush of the valid block-zero slot
    send_req(OP_ALLOC, 32'h0000_0000, 5'h1f);
    send_req(OP_FLUSH, 32'h0000_0000, 5'd0);
    send_req(OP_LOAD,  32'ha5a5_a5a5, 5'h15);
    send_req(OP_LOAD,  32'h5a5a_5a5a, 5'h0a);
    send_req(OP_ALLOC, 32'h8000_0001, 5'h1f);
    send_req(OP_FREE,  32'h0000_0000, 5'h1f);
    send_req(OP_FREE,  32'ha5a5_a5a5, 5'h00);
    send_req(OP_LOAD,  32'h5a5a_5a5a, 5'h1f);
  endtask

  // Fill every slot with dirty blocks (one of them block zero), then miss
  // repeatedly so victims are chosen by stamp and written back.
  task automatic test_fill_and_evict();
    send_req(OP_ALLOC, 32'h0000_0000, 5'($urandom_range(0, 31)));
    for (int i = 1; i < SLOTS_DEF; i++)
      send_req(OP_ALLOC, $urandom(), 5'($urandom_range(0, 31)));
    for (int i = 0; i < 8; i++)
      send_req(OP_LOAD, $urandom(), 5'($urandom_range(0, 31)));
  endtask

  // Random traffic; switch idling on and off in stretches.
  task automatic test_random_mix(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) idle_enable = ($urandom_range(0, 2) != 0);
      send_random_req();
    end
    idle_enable = 1'b1;
  endtask

  // Hold the receiver off for a long stretch while requests keep coming.
  task automatic test_backpressure();
    idle_enable  = 1'b0;
    hold_request = HOLD_CYC;
    repeat (12) send_random_req();
    idle_enable  = 1'b1;
  endtask

  task automatic test_streaming(input int count);
    idle_enable = 1'b0;
    repeat (count) send_random_req();
  endtask

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------

  // Drive ready at falling edges: long hold-off first, then random stall
  // bursts while idling is on.
  initial begin : result_sink
    int stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        stall_left   = hold_request;
        hold_request = 0;
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (idle_enable && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 7) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic note_mismatch(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    mismatch_cnt++;
    if (mismatch_cnt <= REPORT_MAX)
      $display("%0t ns: %s mismatch, expected %h, got %h",
               $realtime, field, want, got);
  endtask

  // Compare each reply transfer with the oldest queued prediction.
  always @(posedge clk) begin : reply_check
    ncl_out_t want;
    ncl_out_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (reply_q.size() == 0) begin
        note_mismatch("unexpected reply", '0, {27'b0, got.slot});
      end else begin
        want = reply_q.pop_front();
        if (got.slot !== want.slot)
          note_mismatch("slot", 32'(want.slot), 32'(got.slot));
        if (got.hit !== want.hit)
          note_mismatch("hit", 32'(want.hit), 32'(got.hit));
        if (got.fill_needed !== want.fill_needed)
          note_mismatch("fill_needed", 32'(want.fill_needed), 32'(got.fill_needed));
        if (got.writeback !== want.writeback)
          note_mismatch("writeback", 32'(want.writeback), 32'(got.writeback));
        if (got.writeback_block !== want.writeback_block)
          note_mismatch("writeback_block", want.writeback_block, got.writeback_block);
      end
    end
  end

  // End the run when no transfer happens on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    idle_enable  = 1'b1;
    hold_request = 0;
    mismatch_cnt = 0;
    use_clk      = '0;
    for (int i = 0; i < SLOTS_DEF; i++) begin
      tag_q[i]   = '0;
      stamp_q[i] = '0;
      dirty_q[i] = 1'b0;
    end
    // pool holds both address extremes plus random blocks
    block_pool[0] = '0;
    block_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) block_pool[i] = $urandom();

    repeat (RESET_CYC) @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_fill_and_evict();
    test_random_mix(400);
    test_backpressure();
    test_streaming(80);

    // drop valid, drain the replies, then watch for strays
    in_ch.valid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    if (mismatch_cnt == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

>>> node_cache_lru_policy.f
rtl/ncl_pkg.sv
rtl/ncl_stream_if.sv
rtl/ncl_ram.sv
rtl/node_cache_lru_policy.sv
tb/tb_node_cache_lru_policy.sv
